FILE: rtl/cdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame deframer package
// Sequencer states, register indexes, frame layout constants and the
// byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package cdf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HDR0,
    ST_HDR1,
    ST_LEN0,
    ST_LEN1,
    ST_CRC,
    ST_CRCLO,
    ST_CRCHI,
    ST_CMD0,
    ST_CMD1,
    ST_GATHER,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_PAYLOAD_LIMIT = 3'd2,
    REG_ENTER_CODE    = 3'd3,
    REG_FIRMWARE_CODE = 3'd4
  } reg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] KIND_ENTER    = 2'd0;
  localparam logic [1:0] KIND_FIRMWARE = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd2;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h5A;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'hA5;
  localparam logic [8:0]  PAYLOAD_LIMIT_RST = 9'd256;
  localparam logic [15:0] ENTER_CODE_RST    = 16'h0002;
  localparam logic [15:0] FIRMWARE_CODE_RST = 16'h0001;

  // Byte offsets within a frame.
  localparam int FRAME_OVERHEAD = 12;
  localparam int CRC_BASE       = 10;
  localparam int OFF_CMD_HI     = 2;
  localparam int OFF_CMD_LO     = 3;
  localparam int OFF_LEN_HI     = 4;
  localparam int OFF_LEN_LO     = 5;
  localparam int OFF_PAYLOAD    = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One byte through the reflected CRC-16/MODBUS register.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/cdf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame deframer channel interfaces
// Received byte channel, chunk result channel and register write channel.
// ----------------------------------------------------------------------------
interface cdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cdf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [7:0]  cmd_high;
  logic [7:0]  cmd_low;
  logic [8:0]  frame_payload_len;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic        last;
  modport source (output valid, output frame_kind, output cmd_high, output cmd_low,
                  output frame_payload_len, output chunk_data, output chunk_bytes,
                  output last, input ready);
  modport sink (input valid, input frame_kind, input cmd_high, input cmd_low,
                input frame_payload_len, input chunk_data, input chunk_bytes,
                input last, output ready);
endinterface

interface cdf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cdf_pkg::CFG_IDX_W-1:0]   index;
  logic [cdf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/crc_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC checked frame deframer
// Buffers received bytes, finds headed frames, checks their CRC-16/MODBUS
// and delivers each good frame as a run of payload chunks.
// ----------------------------------------------------------------------------
// Usage:
// Bytes arrive on rx_i, one per transfer. Each byte is written to a circular
// store and then a sequencer scans the store from its oldest byte, using one
// memory read port. rx_i.ready is high only while the sequencer is idle.
// Every byte is accepted and then the fill level is checked. With two or
// more bytes buffered the header test then runs, and each byte dropped on
// a bad header returns to the fill check before the test repeats. Once six
// bytes are buffered the length test then runs. A byte that completes a
// frame then starts the CRC pass (one byte per cycle, then the two CRC
// bytes), the command bytes are read and the chunks are gathered and
// loaded, one payload byte per cycle, when the receiver does not stall.
// A failed length or CRC check drops two bytes and restarts the scan.
// Chunks leave through a single output register on res_o; when the receiver
// stalls, the sequencer waits before the next chunk is loaded.
// Registers are written on cfg_i (always ready); the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Reset empties the store and loads the register defaults; store contents
// are never used before they are written.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer #(
  parameter int MAX_PAYLOAD = 256,
  parameter int CHUNK_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdf_rx_if.sink     rx_i,
  cdf_res_if.source  res_o,
  cdf_cfg_if.sink    cfg_i
);

  localparam int DEPTH = MAX_PAYLOAD + cdf_pkg::FRAME_OVERHEAD;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PL_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int KW    = $clog2(CHUNK_BYTES + 1);

  cdf_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0] head_q;
  logic [CNT_W-1:0] count_q;
  logic [7:0]       rd_data_q;
  logic [7:0]       store_mem [DEPTH];

  logic [7:0]  header_first_q, header_second_q;
  logic [8:0]  payload_limit_q;
  logic [15:0] enter_code_q, firmware_code_q;

  logic             b0ok_q;
  logic [7:0]       len_hi_q;
  logic [PL_W-1:0]  plen_q;
  logic [PTR_W-1:0] idx_q;
  logic [15:0]      crc_q;
  logic [7:0]       crc_lo_q;
  logic [7:0]       cmd_hi_q, cmd_lo_q;
  logic [1:0]       kind_q;
  logic [PL_W-1:0]  pos_q;
  logic [KW-1:0]    k_q;
  logic [63:0]      data_q;
  logic             last_q;

  logic        res_valid_q;
  logic [1:0]  res_kind_q;
  logic [7:0]  res_cmd_hi_q, res_cmd_lo_q;
  logic [8:0]  res_len_q;
  logic [63:0] res_data_q;
  logic [3:0]  res_bytes_q;
  logic        res_last_q;

  // Shared control and datapath terms.
  logic             rx_fire;
  logic [PTR_W-1:0] rd_off;
  logic             drop_en;
  logic [CNT_W-1:0] drop_n;
  logic [PTR_W:0]   rsum, wsum;
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W:0]   hsum;
  logic [15:0]      lim16, len_full;
  logic             hdr_bad, len_bad, frame_short, crc_last, crc_bad;
  logic [CNT_W-1:0] flen_now, flen_q;
  logic [PTR_W-1:0] crc_at;
  logic [15:0]      crc_next;
  logic [PL_W-1:0]  pos_inc;
  logic             gather_end, out_free;
  logic [2:0]       lane;
  logic [15:0]      code;

  assign rx_fire  = rx_i.valid && rx_i.ready;
  assign out_free = !res_valid_q || res_o.ready;

  assign lim16 = (32'(payload_limit_q) > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD)
                                                      : 16'(payload_limit_q);
  assign len_full    = {len_hi_q, rd_data_q};
  assign hdr_bad     = !(b0ok_q && (rd_data_q == header_second_q));
  assign len_bad     = len_full > lim16;
  assign flen_now    = CNT_W'(len_full) + CNT_W'(cdf_pkg::FRAME_OVERHEAD);
  assign frame_short = count_q < flen_now;
  assign flen_q      = CNT_W'(plen_q) + CNT_W'(cdf_pkg::FRAME_OVERHEAD);
  assign crc_at      = PTR_W'(plen_q) + PTR_W'(cdf_pkg::CRC_BASE);
  assign crc_last    = idx_q == (crc_at - PTR_W'(1));
  assign crc_next    = cdf_pkg::crc16_byte(crc_q, rd_data_q);
  assign crc_bad     = {rd_data_q, crc_lo_q} != crc_q;
  assign pos_inc     = pos_q + PL_W'(1);
  assign gather_end  = (k_q == KW'(CHUNK_BYTES - 1)) || (pos_inc == plen_q);
  assign lane        = 3'(k_q);
  assign code        = {cmd_hi_q, rd_data_q};

  // Logical offsets map onto the circular store.
  assign rsum   = (PTR_W+1)'(head_q) + (PTR_W+1)'(rd_off);
  assign rd_ptr = (32'(rsum) >= DEPTH) ? PTR_W'(32'(rsum) - DEPTH) : PTR_W'(rsum);
  assign wsum   = (PTR_W+1)'(head_q) + (PTR_W+1)'(PTR_W'(count_q));
  assign wr_ptr = (32'(wsum) >= DEPTH) ? PTR_W'(32'(wsum) - DEPTH) : PTR_W'(wsum);
  assign hsum   = (CNT_W+1)'(head_q) + (CNT_W+1)'(drop_n);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cdf_pkg::ST_IDLE:   if (rx_fire) state_d = cdf_pkg::ST_CHECK;
      cdf_pkg::ST_CHECK:  state_d = (count_q < CNT_W'(2)) ? cdf_pkg::ST_IDLE
                                                          : cdf_pkg::ST_HDR0;
      cdf_pkg::ST_HDR0:   state_d = cdf_pkg::ST_HDR1;
      cdf_pkg::ST_HDR1: begin
        if (hdr_bad) state_d = cdf_pkg::ST_CHECK;
        else if (count_q < CNT_W'(6)) state_d = cdf_pkg::ST_IDLE;
        else state_d = cdf_pkg::ST_LEN0;
      end
      cdf_pkg::ST_LEN0:   state_d = cdf_pkg::ST_LEN1;
      cdf_pkg::ST_LEN1: begin
        if (len_bad) state_d = cdf_pkg::ST_CHECK;
        else if (frame_short) state_d = cdf_pkg::ST_IDLE;
        else state_d = cdf_pkg::ST_CRC;
      end
      cdf_pkg::ST_CRC:    if (crc_last) state_d = cdf_pkg::ST_CRCLO;
      cdf_pkg::ST_CRCLO:  state_d = cdf_pkg::ST_CRCHI;
      cdf_pkg::ST_CRCHI:  state_d = crc_bad ? cdf_pkg::ST_CHECK : cdf_pkg::ST_CMD0;
      cdf_pkg::ST_CMD0:   state_d = cdf_pkg::ST_CMD1;
      cdf_pkg::ST_CMD1:   state_d = (plen_q == '0) ? cdf_pkg::ST_EMIT
                                                   : cdf_pkg::ST_GATHER;
      cdf_pkg::ST_GATHER: if (gather_end) state_d = cdf_pkg::ST_EMIT;
      cdf_pkg::ST_EMIT: begin
        if (out_free) state_d = last_q ? cdf_pkg::ST_CHECK : cdf_pkg::ST_GATHER;
      end
      default:            state_d = cdf_pkg::ST_IDLE;
    endcase
  end

  // Read address, drops and input ready.
  always_comb begin
    rd_off     = '0;
    drop_en    = 1'b0;
    drop_n     = '0;
    rx_i.ready = 1'b0;
    case (state_q)
      cdf_pkg::ST_IDLE:  rx_i.ready = 1'b1;
      cdf_pkg::ST_CHECK: rd_off = '0;
      cdf_pkg::ST_HDR0:  rd_off = PTR_W'(1);
      cdf_pkg::ST_HDR1: begin
        if (hdr_bad) begin
          drop_en = 1'b1;
          drop_n  = CNT_W'(1);
        end else begin
          rd_off = PTR_W'(cdf_pkg::OFF_LEN_HI);
        end
      end
      cdf_pkg::ST_LEN0:  rd_off = PTR_W'(cdf_pkg::OFF_LEN_LO);
      cdf_pkg::ST_LEN1: begin
        if (len_bad) begin
          drop_en = 1'b1;
          drop_n  = CNT_W'(2);
        end
      end
      cdf_pkg::ST_CRC:   rd_off = crc_last ? crc_at : (idx_q + PTR_W'(1));
      cdf_pkg::ST_CRCLO: rd_off = crc_at + PTR_W'(1);
      cdf_pkg::ST_CRCHI: begin
        if (crc_bad) begin
          drop_en = 1'b1;
          drop_n  = CNT_W'(2);
        end else begin
          rd_off = PTR_W'(cdf_pkg::OFF_CMD_HI);
        end
      end
      cdf_pkg::ST_CMD0:   rd_off = PTR_W'(cdf_pkg::OFF_CMD_LO);
      cdf_pkg::ST_CMD1:   rd_off = PTR_W'(cdf_pkg::OFF_PAYLOAD);
      cdf_pkg::ST_GATHER: rd_off = PTR_W'(pos_inc) + PTR_W'(cdf_pkg::OFF_PAYLOAD);
      cdf_pkg::ST_EMIT: begin
        rd_off = PTR_W'(pos_q) + PTR_W'(cdf_pkg::OFF_PAYLOAD);
        if (out_free && last_q) begin
          drop_en = 1'b1;
          drop_n  = flen_q;
        end
      end
      default: rd_off = '0;
    endcase
  end

  // Frame store.
  always_ff @(posedge clk_i) begin
    if (rx_fire && (32'(count_q) < DEPTH)) begin
      store_mem[wr_ptr] <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= store_mem[rd_ptr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdf_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rx_fire && (32'(count_q) < DEPTH)) begin
        count_q <= count_q + CNT_W'(1);
      end else if (drop_en) begin
        count_q <= count_q - drop_n;
        head_q  <= (32'(hsum) >= DEPTH) ? PTR_W'(32'(hsum) - DEPTH) : PTR_W'(hsum);
      end
      if (state_q == cdf_pkg::ST_EMIT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= cdf_pkg::HEADER_FIRST_RST;
      header_second_q <= cdf_pkg::HEADER_SECOND_RST;
      payload_limit_q <= cdf_pkg::PAYLOAD_LIMIT_RST;
      enter_code_q    <= cdf_pkg::ENTER_CODE_RST;
      firmware_code_q <= cdf_pkg::FIRMWARE_CODE_RST;
    end else if (cfg_i.valid) begin
      case (cdf_pkg::reg_idx_e'(cfg_i.index))
        cdf_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg_i.data[7:0];
        cdf_pkg::REG_HEADER_SECOND: header_second_q <= cfg_i.data[7:0];
        cdf_pkg::REG_PAYLOAD_LIMIT: payload_limit_q <= cfg_i.data[8:0];
        cdf_pkg::REG_ENTER_CODE:    enter_code_q    <= cfg_i.data;
        cdf_pkg::REG_FIRMWARE_CODE: firmware_code_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Scan datapath and result payload.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cdf_pkg::ST_HDR0: b0ok_q <= rd_data_q == header_first_q;
      cdf_pkg::ST_LEN0: len_hi_q <= rd_data_q;
      cdf_pkg::ST_LEN1: begin
        plen_q <= PL_W'(len_full);
        idx_q  <= '0;
        crc_q  <= cdf_pkg::CRC_INIT;
      end
      cdf_pkg::ST_CRC: begin
        crc_q <= crc_next;
        idx_q <= idx_q + PTR_W'(1);
      end
      cdf_pkg::ST_CRCLO: crc_lo_q <= rd_data_q;
      cdf_pkg::ST_CMD0:  cmd_hi_q <= rd_data_q;
      cdf_pkg::ST_CMD1: begin
        cmd_lo_q <= rd_data_q;
        if (code == enter_code_q) kind_q <= cdf_pkg::KIND_ENTER;
        else if (code == firmware_code_q) kind_q <= cdf_pkg::KIND_FIRMWARE;
        else kind_q <= cdf_pkg::KIND_UNKNOWN;
        pos_q  <= '0;
        k_q    <= '0;
        data_q <= '0;
        last_q <= plen_q == '0;
      end
      cdf_pkg::ST_GATHER: begin
        data_q[8*lane +: 8] <= rd_data_q;
        k_q    <= k_q + KW'(1);
        pos_q  <= pos_inc;
        last_q <= pos_inc == plen_q;
      end
      cdf_pkg::ST_EMIT: begin
        if (out_free) begin
          res_kind_q   <= kind_q;
          res_cmd_hi_q <= cmd_hi_q;
          res_cmd_lo_q <= cmd_lo_q;
          res_len_q    <= 9'(plen_q);
          res_data_q   <= data_q;
          res_bytes_q  <= 4'(k_q);
          res_last_q   <= last_q;
          data_q       <= '0;
          k_q          <= '0;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.frame_kind        = res_kind_q;
  assign res_o.cmd_high          = res_cmd_hi_q;
  assign res_o.cmd_low           = res_cmd_lo_q;
  assign res_o.frame_payload_len = res_len_q;
  assign res_o.chunk_data        = res_data_q;
  assign res_o.chunk_bytes       = res_bytes_q;
  assign res_o.last              = res_last_q;

  // Assertions.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH) else $error("store count beyond depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < DEPTH) else $error("store head beyond depth");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire |=> (state_q == cdf_pkg::ST_CHECK)) else $error("no scan after byte");

  a_gather_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdf_pkg::ST_GATHER) |-> ((32'(k_q) < CHUNK_BYTES) && (pos_q < plen_q)))
    else $error("chunk gather out of range");

endmodule
